// ===== rtl/core/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared constants, codes and types for the strongly connected components
// block: sizes, function and status codes, engine states, channel structs.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

  // graph capacity
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned MaxEdges    = 512;

  // widths
  localparam int unsigned VtxW  = $clog2(MaxVertices);   // vertex / component index
  localparam int unsigned EdgeW = $clog2(MaxEdges);      // edge store address
  localparam int unsigned EptrW = EdgeW + 1;             // edge pointer incl. end mark
  localparam int unsigned CntW  = VtxW + 1;              // vertex count, stack depth
  localparam int unsigned FuncW = 3;
  localparam int unsigned StatW = 2;

  // end-of-list mark for edge pointers
  localparam logic [EptrW-1:0] Nil = EptrW'(MaxEdges);

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD    = 3'd0,
    FUNC_RUN    = 3'd1,
    FUNC_VCOMP  = 3'd2,
    FUNC_CSIZE  = 3'd3,
    FUNC_COUNT  = 3'd4,
    FUNC_LINK   = 3'd5,
    FUNC_CLEAR  = 3'd6
  } scc_func_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_NO_RUN = 2'd3
  } scc_status_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD1,
    ST_ADD2,
    ST_QRD,
    ST_P1_ROOT,
    ST_P1_HEAD,
    ST_P1_STEP,
    ST_P1_POP,
    ST_P1_EDGE,
    ST_P2_ROOT,
    ST_P2_RCHK,
    ST_P2_VISIT,
    ST_P2_INHD,
    ST_P2_STEP,
    ST_P2_POPD,
    ST_P2_EDGE,
    ST_LK_RD,
    ST_LK_EP,
    ST_LK_CMP,
    ST_LK_WR,
    ST_DONE
  } scc_state_e;

  // one accepted item as seen by the engine
  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [VtxW-1:0]  node_or_component;
    logic [VtxW-1:0]  target;
  } scc_req_t;

  // one result item
  typedef struct packed {
    logic [StatW-1:0] status;
    logic [CntW-1:0]  value;
    logic             linked;
  } scc_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/scc_in_if.sv =====
// ----------------------------------------------------------------------------
// scc_in_if
// Command channel: function code and two index fields, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [5:0] node_or_component;
  logic [5:0] target;

  modport source (output valid, func, node_or_component, target, input ready);
  modport sink   (input valid, func, node_or_component, target, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/scc_out_if.sv =====
// ----------------------------------------------------------------------------
// scc_out_if
// Result channel: status, value and link flag, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [6:0] value;
  logic       linked;

  modport source (output valid, status, value, linked, input ready);
  modport sink   (input valid, status, value, linked, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/scc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// scc_cfg_if
// Configuration write channel for the vertex count register, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/scc_engine.sv =====
// ----------------------------------------------------------------------------
// scc_engine
// Edge store, depth-first walk sequencer and result stores. Edge lists, list
// heads and result tables sit in single-port-write synchronous memories; a
// sequencer walks them with an explicit stack for both Kosaraju passes.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  scc_pkg::scc_req_t           req_i,
  input  logic                        cfg_we_i,
  input  logic [scc_pkg::CntW-1:0]    vertex_count_i,
  output logic                        idle_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output scc_pkg::scc_res_t           res_o
);
  import scc_pkg::*;

  // memories
  logic [VtxW-1:0]    esrc_mem [MaxEdges];
  logic [VtxW-1:0]    etgt_mem [MaxEdges];
  logic [EptrW-1:0]   enout_mem[MaxEdges];
  logic [EptrW-1:0]   enin_mem [MaxEdges];
  logic [2*EptrW-1:0] oht_mem  [MaxVertices];
  logic [EptrW-1:0]   inh_mem  [MaxVertices];
  logic [VtxW-1:0]    fin_mem  [MaxVertices];
  logic [VtxW+EptrW-1:0] stk_mem [MaxVertices];
  logic [VtxW-1:0]    cof_mem  [MaxVertices];
  logic [CntW-1:0]    csz_mem  [MaxVertices];
  logic [MaxVertices-1:0] lnk_mem [MaxVertices];

  // registered read data
  logic [VtxW-1:0]    esrc_rd_q, etgt_rd_q;
  logic [EptrW-1:0]   enout_rd_q, enin_rd_q;
  logic [2*EptrW-1:0] oht_rd_q;
  logic [EptrW-1:0]   inh_rd_q;
  logic [VtxW-1:0]    fin_rd_q;
  logic [VtxW+EptrW-1:0] stk_rd_q;
  logic [VtxW-1:0]    cof_rd1_q, cof_rd2_q;
  logic [CntW-1:0]    csz_rd_q;
  logic [MaxVertices-1:0] lnk_rd_q;

  // memory controls
  logic [EdgeW-1:0]   e_raddr, e_waddr, nout_waddr;
  logic               e_we, nout_we;
  logic [EptrW-1:0]   nout_wdata, nin_wdata;
  logic [VtxW-1:0]    oht_raddr, inh_raddr, fin_raddr, stk_raddr, stk_waddr;
  logic               oht_we, inh_we, fin_we, stk_we, cof_we, csz_we, lnk_we;
  logic [2*EptrW-1:0] oht_wdata;
  logic [VtxW+EptrW-1:0] stk_wdata;
  logic [VtxW-1:0]    cof_ra1, cof_ra2, csz_raddr, lnk_raddr;
  logic [MaxVertices-1:0] lnk_wdata;

  // control state
  scc_state_e             state_q, state_d;
  logic [EptrW-1:0]       total_q, total_d;
  logic                   rv_q, rv_d;
  logic [CntW-1:0]        ctot_q, ctot_d;
  logic [MaxVertices-1:0] ov_q, ov_d, iv_q, iv_d, vis_q, vis_d, lrv_q, lrv_d;

  // walk registers
  scc_req_t         req_q, req_d;
  logic [CntW-1:0]  r_q, r_d, sp_q, sp_d, fin_q, fin_d, idx_q, idx_d, size_q, size_d;
  logic [VtxW-1:0]  topv_q, topv_d, curv_q, curv_d, comp_q, comp_d, la_q, la_d, lb_q, lb_d;
  logic [EptrW-1:0] tope_q, tope_d, ecur_q, ecur_d;
  logic [EdgeW-1:0] tail_q, tail_d;
  scc_res_t         res_q, res_d;

  // decoded helpers
  logic [CntW-1:0]  n_w;
  logic [VtxW-1:0]  a_w, b_w;
  scc_func_e        func_w;

  assign n_w    = (vertex_count_i > CntW'(MaxVertices)) ? CntW'(MaxVertices) : vertex_count_i;
  assign a_w    = req_q.node_or_component;
  assign b_w    = req_q.target;
  assign func_w = scc_func_e'(req_q.func);

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  // edge store
  always_ff @(posedge clk_i) begin
    if (e_we) begin
      esrc_mem[e_waddr] <= a_w;
      etgt_mem[e_waddr] <= b_w;
      enin_mem[e_waddr] <= nin_wdata;
    end
    if (nout_we) begin
      enout_mem[nout_waddr] <= nout_wdata;
    end
    esrc_rd_q  <= esrc_mem[e_raddr];
    etgt_rd_q  <= etgt_mem[e_raddr];
    enout_rd_q <= enout_mem[e_raddr];
    enin_rd_q  <= enin_mem[e_raddr];
  end

  // per-vertex list heads
  always_ff @(posedge clk_i) begin
    if (oht_we) begin
      oht_mem[a_w] <= oht_wdata;
    end
    if (inh_we) begin
      inh_mem[b_w] <= total_q;
    end
    oht_rd_q <= oht_mem[oht_raddr];
    inh_rd_q <= inh_mem[inh_raddr];
  end

  // finish order and walk stack
  always_ff @(posedge clk_i) begin
    if (fin_we) begin
      fin_mem[fin_q[VtxW-1:0]] <= topv_q;
    end
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    fin_rd_q <= fin_mem[fin_raddr];
    stk_rd_q <= stk_mem[stk_raddr];
  end

  // component results and link matrix
  always_ff @(posedge clk_i) begin
    if (cof_we) begin
      cof_mem[curv_q] <= comp_q;
    end
    if (csz_we) begin
      csz_mem[comp_q] <= size_q;
    end
    if (lnk_we) begin
      lnk_mem[la_q] <= lnk_wdata;
    end
    cof_rd1_q <= cof_mem[cof_ra1];
    cof_rd2_q <= cof_mem[cof_ra2];
    csz_rd_q  <= csz_mem[csz_raddr];
    lnk_rd_q  <= lnk_mem[lnk_raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      rv_q    <= 1'b0;
      ctot_q  <= '0;
      ov_q    <= '0;
      iv_q    <= '0;
      vis_q   <= '0;
      lrv_q   <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      rv_q    <= rv_d;
      ctot_q  <= ctot_d;
      ov_q    <= ov_d;
      iv_q    <= iv_d;
      vis_q   <= vis_d;
      lrv_q   <= lrv_d;
    end
  end

  // walk and payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    r_q    <= r_d;
    sp_q   <= sp_d;
    fin_q  <= fin_d;
    idx_q  <= idx_d;
    size_q <= size_d;
    topv_q <= topv_d;
    curv_q <= curv_d;
    comp_q <= comp_d;
    la_q   <= la_d;
    lb_q   <= lb_d;
    tope_q <= tope_d;
    ecur_q <= ecur_d;
    tail_q <= tail_d;
    res_q  <= res_d;
  end

  // sequencer
  always_comb begin
    logic [VtxW-1:0] t_v;
    logic [VtxW-1:0] s_v;
    logic [EptrW-1:0] hd_v;

    state_d = state_q;
    total_d = total_q;
    rv_d    = rv_q;
    ctot_d  = ctot_q;
    ov_d    = ov_q;
    iv_d    = iv_q;
    vis_d   = vis_q;
    lrv_d   = lrv_q;
    req_d   = req_q;
    r_d     = r_q;
    sp_d    = sp_q;
    fin_d   = fin_q;
    idx_d   = idx_q;
    size_d  = size_q;
    topv_d  = topv_q;
    curv_d  = curv_q;
    comp_d  = comp_q;
    la_d    = la_q;
    lb_d    = lb_q;
    tope_d  = tope_q;
    ecur_d  = ecur_q;
    tail_d  = tail_q;
    res_d   = res_q;

    e_raddr    = ecur_q[EdgeW-1:0];
    e_waddr    = total_q[EdgeW-1:0];
    e_we       = 1'b0;
    nout_we    = 1'b0;
    nout_waddr = total_q[EdgeW-1:0];
    nout_wdata = Nil;
    nin_wdata  = iv_q[b_w] ? inh_rd_q : Nil;
    oht_raddr  = a_w;
    oht_we     = 1'b0;
    oht_wdata  = {(ov_q[a_w] ? oht_rd_q[2*EptrW-1:EptrW] : total_q), total_q};
    inh_raddr  = b_w;
    inh_we     = 1'b0;
    fin_we     = 1'b0;
    fin_raddr  = VtxW'(idx_q - CntW'(1));
    stk_we     = 1'b0;
    stk_waddr  = VtxW'(sp_q - CntW'(1));
    stk_wdata  = {topv_q, enout_rd_q};
    stk_raddr  = VtxW'(sp_q - CntW'(1));
    cof_we     = 1'b0;
    cof_ra1    = a_w;
    cof_ra2    = b_w;
    csz_we     = 1'b0;
    csz_raddr  = a_w;
    lnk_we     = 1'b0;
    lnk_raddr  = a_w;
    lnk_wdata  = (lrv_q[la_q] ? lnk_rd_q : '0) | (MaxVertices'(1) << lb_q);

    t_v  = etgt_rd_q;
    s_v  = esrc_rd_q;
    hd_v = ov_q[topv_q] ? oht_rd_q[2*EptrW-1:EptrW] : Nil;

    // any register write discards the last run
    if (cfg_we_i) begin
      rv_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res_d = '{status: STAT_OK, value: '0, linked: 1'b0};
        state_d = ST_DONE;
        unique case (func_w)
          FUNC_ADD: begin
            if ({1'b0, a_w} >= n_w || {1'b0, b_w} >= n_w) begin
              res_d.status = STAT_RANGE;
            end else if (total_q >= EptrW'(MaxEdges)) begin
              res_d.status = STAT_FULL;
            end else begin
              state_d = ST_ADD1;
            end
          end
          FUNC_RUN: begin
            vis_d   = '0;
            r_d     = '0;
            fin_d   = '0;
            state_d = ST_P1_ROOT;
          end
          FUNC_VCOMP: begin
            if (!rv_q) res_d.status = STAT_NO_RUN;
            else if ({1'b0, a_w} >= n_w) res_d.status = STAT_RANGE;
            else state_d = ST_QRD;
          end
          FUNC_CSIZE: begin
            if (!rv_q) res_d.status = STAT_NO_RUN;
            else if ({1'b0, a_w} >= ctot_q) res_d.status = STAT_RANGE;
            else state_d = ST_QRD;
          end
          FUNC_COUNT: begin
            if (!rv_q) res_d.status = STAT_NO_RUN;
            else res_d.value = ctot_q;
          end
          FUNC_LINK: begin
            if (!rv_q) res_d.status = STAT_NO_RUN;
            else if ({1'b0, a_w} >= ctot_q || {1'b0, b_w} >= ctot_q) res_d.status = STAT_RANGE;
            else state_d = ST_QRD;
          end
          FUNC_CLEAR: begin
            ov_d    = '0;
            iv_d    = '0;
            total_d = '0;
            rv_d    = 1'b0;
          end
          default: begin
            res_d.status = STAT_RANGE;
          end
        endcase
      end

      // answer from the result stores
      ST_QRD: begin
        case (func_w)
          FUNC_VCOMP: res_d.value  = {1'b0, cof_rd1_q};
          FUNC_CSIZE: res_d.value  = csz_rd_q;
          default:    res_d.linked = lrv_q[a_w] & lnk_rd_q[b_w];
        endcase
        state_d = ST_DONE;
      end

      // append edge, link into both lists
      ST_ADD1: begin
        e_we     = 1'b1;
        nout_we  = 1'b1;
        oht_we   = 1'b1;
        inh_we   = 1'b1;
        iv_d[b_w] = 1'b1;
        ov_d[a_w] = 1'b1;
        tail_d   = oht_rd_q[EdgeW-1:0];
        rv_d     = 1'b0;
        if (ov_q[a_w]) begin
          state_d = ST_ADD2;
        end else begin
          total_d = total_q + EptrW'(1);
          state_d = ST_DONE;
        end
      end

      ST_ADD2: begin
        nout_we    = 1'b1;
        nout_waddr = tail_q;
        nout_wdata = total_q;
        total_d    = total_q + EptrW'(1);
        state_d    = ST_DONE;
      end

      // first pass: roots in vertex order
      ST_P1_ROOT: begin
        oht_raddr = r_q[VtxW-1:0];
        if (r_q >= n_w) begin
          vis_d   = '0;
          lrv_d   = '0;
          ctot_d  = '0;
          idx_d   = fin_q;
          state_d = ST_P2_ROOT;
        end else if (vis_q[r_q[VtxW-1:0]]) begin
          r_d = r_q + CntW'(1);
        end else begin
          vis_d[r_q[VtxW-1:0]] = 1'b1;
          topv_d  = r_q[VtxW-1:0];
          sp_d    = CntW'(1);
          state_d = ST_P1_HEAD;
        end
      end

      ST_P1_HEAD: begin
        tope_d  = hd_v;
        state_d = ST_P1_STEP;
      end

      ST_P1_STEP: begin
        e_raddr   = tope_q[EdgeW-1:0];
        stk_raddr = VtxW'(sp_q - CntW'(2));
        if (tope_q >= total_q) begin
          fin_we = 1'b1;
          fin_d  = fin_q + CntW'(1);
          sp_d   = sp_q - CntW'(1);
          if (sp_q == CntW'(1)) begin
            r_d     = r_q + CntW'(1);
            state_d = ST_P1_ROOT;
          end else begin
            state_d = ST_P1_POP;
          end
        end else begin
          state_d = ST_P1_EDGE;
        end
      end

      ST_P1_POP: begin
        topv_d  = stk_rd_q[VtxW+EptrW-1:EptrW];
        tope_d  = stk_rd_q[EptrW-1:0];
        state_d = ST_P1_STEP;
      end

      ST_P1_EDGE: begin
        oht_raddr = t_v;
        tope_d    = enout_rd_q;
        state_d   = ST_P1_STEP;
        if ({1'b0, t_v} < n_w && !vis_q[t_v] && sp_q < CntW'(MaxVertices)) begin
          vis_d[t_v] = 1'b1;
          stk_we     = 1'b1;
          stk_wdata  = {topv_q, enout_rd_q};
          topv_d     = t_v;
          sp_d       = sp_q + CntW'(1);
          state_d    = ST_P1_HEAD;
        end
      end

      // second pass: roots in reverse finish order
      ST_P2_ROOT: begin
        if (idx_q == '0) begin
          ecur_d  = '0;
          state_d = ST_LK_RD;
        end else begin
          idx_d   = idx_q - CntW'(1);
          state_d = ST_P2_RCHK;
        end
      end

      ST_P2_RCHK: begin
        if (vis_q[fin_rd_q]) begin
          state_d = ST_P2_ROOT;
        end else begin
          vis_d[fin_rd_q] = 1'b1;
          comp_d  = ctot_q[VtxW-1:0];
          ctot_d  = ctot_q + CntW'(1);
          size_d  = '0;
          curv_d  = fin_rd_q;
          sp_d    = '0;
          state_d = ST_P2_VISIT;
        end
      end

      ST_P2_VISIT: begin
        inh_raddr = curv_q;
        cof_we    = 1'b1;
        size_d    = size_q + CntW'(1);
        state_d   = ST_P2_INHD;
      end

      ST_P2_INHD: begin
        ecur_d  = iv_q[curv_q] ? inh_rd_q : Nil;
        state_d = ST_P2_STEP;
      end

      ST_P2_STEP: begin
        if (ecur_q >= total_q) begin
          if (sp_q == '0) begin
            csz_we  = 1'b1;
            state_d = ST_P2_ROOT;
          end else begin
            sp_d    = sp_q - CntW'(1);
            state_d = ST_P2_POPD;
          end
        end else begin
          state_d = ST_P2_EDGE;
        end
      end

      ST_P2_POPD: begin
        curv_d  = stk_rd_q[VtxW+EptrW-1:EptrW];
        state_d = ST_P2_VISIT;
      end

      ST_P2_EDGE: begin
        ecur_d  = enin_rd_q;
        state_d = ST_P2_STEP;
        if ({1'b0, s_v} < n_w && !vis_q[s_v] && sp_q < CntW'(MaxVertices)) begin
          vis_d[s_v] = 1'b1;
          stk_we     = 1'b1;
          stk_waddr  = sp_q[VtxW-1:0];
          stk_wdata  = {s_v, Nil};
          sp_d       = sp_q + CntW'(1);
        end
      end

      // condensation links, one edge at a time
      ST_LK_RD: begin
        if (ecur_q >= total_q) begin
          rv_d    = 1'b1;
          res_d   = '{status: STAT_OK, value: ctot_q, linked: 1'b0};
          state_d = ST_DONE;
        end else begin
          state_d = ST_LK_EP;
        end
      end

      ST_LK_EP: begin
        cof_ra1 = s_v;
        cof_ra2 = t_v;
        if ({1'b0, s_v} < n_w && {1'b0, t_v} < n_w) begin
          state_d = ST_LK_CMP;
        end else begin
          ecur_d  = ecur_q + EptrW'(1);
          state_d = ST_LK_RD;
        end
      end

      ST_LK_CMP: begin
        lnk_raddr = cof_rd1_q;
        la_d      = cof_rd1_q;
        lb_d      = cof_rd2_q;
        if (cof_rd1_q != cof_rd2_q) begin
          state_d = ST_LK_WR;
        end else begin
          ecur_d  = ecur_q + EptrW'(1);
          state_d = ST_LK_RD;
        end
      end

      ST_LK_WR: begin
        lnk_we     = 1'b1;
        lrv_d[la_q] = 1'b1;
        ecur_d     = ecur_q + EptrW'(1);
        state_d    = ST_LK_RD;
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/strongly_connected_components.sv =====
// ----------------------------------------------------------------------------
// strongly_connected_components
// Strongly connected components of a directed graph by Kosaraju's method.
//
// Channels: in_i takes command items (add edge, run, vertex component,
// component size, count, link query, clear); out_o returns one result item
// per command; cfg_i writes the vertex count register (reset value 64).
// Items are taken one at a time by a memory-based sequencer. An edge load
// decodes, appends the edge and, if its source already has out-edges, links
// it behind the old tail; a query decodes and reads the result stores where
// needed. The next item is taken in the cycle after the result leaves the
// engine. A run walks the edge and head memories in two depth-first passes
// and then visits each edge for the condensation links; input is held off
// meanwhile. The pace is set by the single, registered read port of the
// edge and stack memories.
// Results go through a one-entry output register, so the next item is taken
// while a result waits; a stalled receiver holds that register and then the
// engine. Reset empties the graph, clears the last run and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module strongly_connected_components (
  input  logic     clk_i,
  input  logic     rst_ni,
  scc_in_if.sink   in_i,
  scc_out_if.source out_o,
  scc_cfg_if.sink  cfg_i
);
  import scc_pkg::*;

  logic            eng_idle, eng_res_valid, eng_res_ready, start, cfg_we;
  scc_req_t        req;
  scc_res_t        eng_res;
  logic [CntW-1:0] vc_q;
  logic            ov_q;
  scc_res_t        out_q;

  // command hand-off
  assign in_i.ready = eng_idle;
  assign start      = in_i.valid & in_i.ready;
  assign req        = '{func: in_i.func, node_or_component: in_i.node_or_component,
                        target: in_i.target};

  // vertex count register
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid & cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= CntW'(MaxVertices);
    end else if (cfg_we) begin
      vc_q <= cfg_i.vertex_count;
    end
  end

  scc_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .req_i          (req),
    .cfg_we_i       (cfg_we),
    .vertex_count_i (vc_q),
    .idle_o         (eng_idle),
    .res_valid_o    (eng_res_valid),
    .res_ready_i    (eng_res_ready),
    .res_o          (eng_res)
  );

  // output register
  assign eng_res_ready = ~ov_q | out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (eng_res_ready) begin
      ov_q <= eng_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_res_ready && eng_res_valid) begin
      out_q <= eng_res;
    end
  end

  assign out_o.valid  = ov_q;
  assign out_o.status = out_q.status;
  assign out_o.value  = out_q.value;
  assign out_o.linked = out_q.linked;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for strongly_connected_components. A directed table and random
// graph phases (load edges, run, query) drive the command channel under
// random gaps and receiver stalls. Each result is checked field by field:
// typed commands against fixed values, the rest against a behavioral Kosaraju
// predictor kept in step with each accepted command and vertex count write.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import scc_pkg::*;

  localparam int          NoEdge     = 512;
  localparam logic [2:0]  FuncUnused = 3'd7;

  typedef struct {
    scc_status_e status;
    logic [6:0]  value;
    logic        linked;
  } scc_result_t;

  typedef struct {
    logic [2:0]  func;
    logic [5:0]  a;
    logic [5:0]  b;
    bit          typed;
    scc_status_e status;
    logic [6:0]  value;
    logic        linked;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  scc_in_if  cmd_if ();
  scc_out_if res_if ();
  scc_cfg_if cfg_if ();

  strongly_connected_components dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // graph copy kept by the predictor
  int         g_src [NoEdge];
  int         g_tgt [NoEdge];
  int         g_nout [NoEdge];
  int         g_nin [NoEdge];
  int         g_ohead [64];
  int         g_otail [64];
  int         g_ihead [64];
  int         g_etotal;
  logic [6:0] g_vcount;
  int         g_comp_of [64];
  int         g_csize [64];
  int         g_ctotal;
  bit [63:0]  g_link [64];
  bit         g_run_ok;

  scc_result_t pending_q [$];
  int          errors;
  bit          quiet;
  bit          hold_go;
  int          hold_cnt;
  int          rx_stall;

  function automatic int live_n();
    return (g_vcount > 64) ? 64 : int'(g_vcount);
  endfunction

  function automatic void drop_edges();
    for (int i = 0; i < 64; i++) begin
      g_ohead[i] = NoEdge;
      g_otail[i] = NoEdge;
      g_ihead[i] = NoEdge;
    end
    g_etotal = 0;
    g_run_ok = 1'b0;
  endfunction

  // two-pass Kosaraju with explicit stacks, then condensation links
  function automatic void find_components();
    int n, fin, sp, e, t, v, c, s, d;
    bit vis [64];
    int order [64];
    int stk_v [64];
    int stk_e [64];
    n = live_n();
    fin = 0;
    for (int i = 0; i < 64; i++) vis[i] = 1'b0;
    for (int r = 0; r < n; r++) begin
      if (!vis[r]) begin
        vis[r] = 1'b1;
        stk_v[0] = r;
        stk_e[0] = g_ohead[r];
        sp = 1;
        while (sp > 0) begin
          v = stk_v[sp-1];
          e = stk_e[sp-1];
          if (e >= g_etotal) begin
            sp--;
            if (fin < 64) begin
              order[fin] = v;
              fin++;
            end
          end else begin
            stk_e[sp-1] = g_nout[e];
            t = g_tgt[e];
            if (t < n && !vis[t] && sp < 64) begin
              vis[t] = 1'b1;
              stk_v[sp] = t;
              stk_e[sp] = g_ohead[t];
              sp++;
            end
          end
        end
      end
    end
    for (int i = 0; i < 64; i++) begin
      vis[i] = 1'b0;
      g_csize[i] = 0;
      g_link[i] = '0;
    end
    g_ctotal = 0;
    for (int idx = fin; idx > 0; idx--) begin
      int r;
      r = order[idx-1];
      if (!vis[r]) begin
        c = g_ctotal;
        g_ctotal++;
        vis[r] = 1'b1;
        stk_v[0] = r;
        sp = 1;
        while (sp > 0) begin
          sp--;
          v = stk_v[sp];
          g_comp_of[v] = c;
          g_csize[c]++;
          for (e = g_ihead[v]; e < g_etotal; e = g_nin[e]) begin
            s = g_src[e];
            if (s < n && !vis[s] && sp < 64) begin
              vis[s] = 1'b1;
              stk_v[sp] = s;
              sp++;
            end
          end
        end
      end
    end
    for (e = 0; e < g_etotal; e++) begin
      s = g_src[e];
      d = g_tgt[e];
      if (s < n && d < n && g_comp_of[s] != g_comp_of[d])
        g_link[g_comp_of[s]][g_comp_of[d]] = 1'b1;
    end
    g_run_ok = 1'b1;
  endfunction

  // apply one command to the predictor and return its result item
  function automatic scc_result_t predict_result(logic [2:0] f, int a, int b);
    scc_result_t r;
    int n, e;
    n = live_n();
    r.status = STAT_OK;
    r.value  = '0;
    r.linked = 1'b0;
    case (f)
      FUNC_ADD: begin
        if (a >= n || b >= n) r.status = STAT_RANGE;
        else if (g_etotal >= NoEdge) r.status = STAT_FULL;
        else begin
          e = g_etotal;
          g_etotal++;
          g_src[e] = a;
          g_tgt[e] = b;
          g_nout[e] = NoEdge;
          if (g_ohead[a] == NoEdge) g_ohead[a] = e;
          else g_nout[g_otail[a]] = e;
          g_otail[a] = e;
          g_nin[e] = g_ihead[b];
          g_ihead[b] = e;
          g_run_ok = 1'b0;
        end
      end
      FUNC_RUN: begin
        find_components();
        r.value = 7'(g_ctotal);
      end
      FUNC_VCOMP: begin
        if (!g_run_ok) r.status = STAT_NO_RUN;
        else if (a >= n) r.status = STAT_RANGE;
        else r.value = 7'(g_comp_of[a]);
      end
      FUNC_CSIZE: begin
        if (!g_run_ok) r.status = STAT_NO_RUN;
        else if (a >= g_ctotal) r.status = STAT_RANGE;
        else r.value = 7'(g_csize[a]);
      end
      FUNC_COUNT: begin
        if (!g_run_ok) r.status = STAT_NO_RUN;
        else r.value = 7'(g_ctotal);
      end
      FUNC_LINK: begin
        if (!g_run_ok) r.status = STAT_NO_RUN;
        else if (a >= g_ctotal || b >= g_ctotal) r.status = STAT_RANGE;
        else r.linked = g_link[a][b];
      end
      FUNC_CLEAR: drop_edges();
      default: r.status = STAT_RANGE;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (at %0t)", what, got, want, $realtime);
    errors++;
  endtask

  // result checking at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result item", 1, 0);
      end else begin
        scc_result_t w;
        w = pending_q.pop_front();
        if (res_if.status !== w.status) report_mismatch("status", res_if.status, w.status);
        if (res_if.value !== w.value) report_mismatch("value", res_if.value, w.value);
        if (res_if.linked !== w.linked) report_mismatch("linked", res_if.linked, w.linked);
      end
      rx_stall = quiet ? 0 : $urandom_range(0, 19);
    end
  end

  // receiver ready with random stalls and a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_cnt = 400;
      hold_go = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      res_if.ready = 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      res_if.ready = 1'b0;
    end else begin
      res_if.ready = 1'b1;
    end
  end

  // offer one command item and record its expected result once accepted
  task automatic send_cmd(logic [2:0] f, logic [5:0] a, logic [5:0] b,
                          bit typed = 1'b0, scc_result_t tv = '{STAT_OK, 7'd0, 1'b0});
    int gap;
    scc_result_t r;
    gap = quiet ? 0 : $urandom_range(0, 19);
    repeat (gap) @(negedge clk_i);
    cmd_if.valid = 1'b1;
    cmd_if.func = f;
    cmd_if.node_or_component = a;
    cmd_if.target = b;
    do @(posedge clk_i); while (!cmd_if.ready);
    r = predict_result(f, a, b);
    if (typed) r = tv;
    pending_q = {pending_q, r};
    @(negedge clk_i);
    cmd_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending_q.size() == 0);
    repeat (10) @(negedge clk_i);
  endtask

  // vertex count write, only with the block idle
  task automatic write_vcount(logic [6:0] v);
    wait_drained();
    cfg_if.valid = 1'b1;
    cfg_if.vertex_count = v;
    do @(posedge clk_i); while (!cfg_if.ready);
    g_vcount = v;
    g_run_ok = 1'b0;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic [5:0] pick_vertex();
    int n;
    n = live_n();
    if (n == 0 || $urandom_range(0, 9) == 0) return 6'($urandom);
    return 6'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [5:0] pick_comp();
    if (g_ctotal == 0 || $urandom_range(0, 9) == 0) return 6'($urandom);
    return 6'($urandom_range(0, g_ctotal - 1));
  endfunction

  // one graph: clear, load edges, run, then queries
  task automatic graph_phase(int n_edges, int n_query);
    logic [2:0] f;
    send_cmd(FUNC_CLEAR, 6'($urandom), 6'($urandom));
    for (int i = 0; i < n_edges; i++) send_cmd(FUNC_ADD, pick_vertex(), pick_vertex());
    if ($urandom_range(0, 3) == 0) send_cmd(3'($urandom), 6'($urandom), 6'($urandom));
    send_cmd(FUNC_RUN, 6'($urandom), 6'($urandom));
    for (int i = 0; i < n_query; i++) begin
      f = ($urandom_range(0, 15) == 0) ? 3'($urandom) : 3'($urandom_range(2, 5));
      if (f == FUNC_VCOMP) send_cmd(f, pick_vertex(), 6'($urandom));
      else send_cmd(f, pick_comp(), pick_comp());
    end
  endtask

  dir_row_t dir_tab [$];

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.func = '0;
    cmd_if.node_or_component = '0;
    cmd_if.target = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.vertex_count = '0;
    errors = 0;
    quiet = 1'b0;
    hold_go = 1'b0;
    hold_cnt = 0;
    rx_stall = 0;
    g_vcount = 7'd64;
    drop_edges();
    g_ctotal = 0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table, vertex count at its reset value
    dir_tab = '{
      '{FUNC_VCOMP, 6'd0, 6'd0, 1'b1, STAT_NO_RUN, 7'd0, 1'b0},
      '{FUNC_COUNT, 6'd0, 6'd0, 1'b1, STAT_NO_RUN, 7'd0, 1'b0},
      '{FUNC_RUN, 6'd0, 6'd0, 1'b1, STAT_OK, 7'd64, 1'b0},
      '{FUNC_COUNT, 6'd63, 6'd63, 1'b1, STAT_OK, 7'd64, 1'b0},
      '{FUNC_VCOMP, 6'd63, 6'd0, 1'b1, STAT_OK, 7'd0, 1'b0},
      '{FUNC_VCOMP, 6'd0, 6'd0, 1'b1, STAT_OK, 7'd63, 1'b0},
      '{FUNC_CSIZE, 6'd63, 6'd0, 1'b1, STAT_OK, 7'd1, 1'b0},
      '{FUNC_LINK, 6'd63, 6'd63, 1'b1, STAT_OK, 7'd0, 1'b0},
      '{FUNC_ADD, 6'd63, 6'd0, 1'b1, STAT_OK, 7'd0, 1'b0},
      '{FUNC_ADD, 6'd0, 6'd63, 1'b1, STAT_OK, 7'd0, 1'b0},
      '{FUNC_ADD, 6'd5, 6'd5, 1'b1, STAT_OK, 7'd0, 1'b0},
      '{FUNC_ADD, 6'd1, 6'd2, 1'b0, STAT_OK, 7'd0, 1'b0},
      '{FUNC_ADD, 6'd2, 6'd1, 1'b0, STAT_OK, 7'd0, 1'b0},
      '{FUNC_ADD, 6'd2, 6'd3, 1'b0, STAT_OK, 7'd0, 1'b0},
      '{FUNC_VCOMP, 6'd0, 6'd0, 1'b1, STAT_NO_RUN, 7'd0, 1'b0},
      '{FUNC_RUN, 6'd0, 6'd0, 1'b0, STAT_OK, 7'd0, 1'b0},
      '{FUNC_VCOMP, 6'd1, 6'd0, 1'b0, STAT_OK, 7'd0, 1'b0},
      '{FUNC_CSIZE, 6'd0, 6'd0, 1'b0, STAT_OK, 7'd0, 1'b0},
      '{FUNC_LINK, 6'd0, 6'd1, 1'b0, STAT_OK, 7'd0, 1'b0},
      '{FUNC_LINK, 6'd1, 6'd0, 1'b0, STAT_OK, 7'd0, 1'b0},
      '{FUNC_CSIZE, 6'd63, 6'd0, 1'b0, STAT_OK, 7'd0, 1'b0},
      '{FuncUnused, 6'd63, 6'd63, 1'b1, STAT_RANGE, 7'd0, 1'b0},
      '{FUNC_CLEAR, 6'd0, 6'd0, 1'b1, STAT_OK, 7'd0, 1'b0},
      '{FUNC_COUNT, 6'd0, 6'd0, 1'b1, STAT_NO_RUN, 7'd0, 1'b0}
    };
    foreach (dir_tab[i])
      send_cmd(dir_tab[i].func, dir_tab[i].a, dir_tab[i].b, dir_tab[i].typed,
               '{dir_tab[i].status, dir_tab[i].value, dir_tab[i].linked});

    // smallest graph: one vertex and bad endpoints
    write_vcount(7'd1);
    send_cmd(FUNC_ADD, 6'd1, 6'd0, 1'b1, '{STAT_RANGE, 7'd0, 1'b0});
    send_cmd(FUNC_ADD, 6'd0, 6'd0);
    send_cmd(FUNC_RUN, 6'd0, 6'd0, 1'b1, '{STAT_OK, 7'd1, 1'b0});
    send_cmd(FUNC_VCOMP, 6'd1, 6'd0, 1'b1, '{STAT_RANGE, 7'd0, 1'b0});
    // empty graph, then oversize count and stale run after write
    write_vcount(7'd0);
    send_cmd(FUNC_RUN, 6'd0, 6'd0, 1'b1, '{STAT_OK, 7'd0, 1'b0});
    send_cmd(FUNC_CSIZE, 6'd0, 6'd0, 1'b1, '{STAT_RANGE, 7'd0, 1'b0});
    write_vcount(7'd127);
    send_cmd(FUNC_VCOMP, 6'd0, 6'd0, 1'b1, '{STAT_NO_RUN, 7'd0, 1'b0});
    graph_phase(20, 6);

    // full edge store on the largest graph
    write_vcount(7'd64);
    quiet = 1'b1;
    send_cmd(FUNC_CLEAR, 6'd0, 6'd0);
    for (int i = 0; i < 514; i++) send_cmd(FUNC_ADD, 6'($urandom), 6'($urandom));
    send_cmd(FUNC_RUN, 6'd0, 6'd0);
    for (int i = 0; i < 8; i++) send_cmd(3'($urandom_range(2, 5)), pick_comp(), pick_comp());
    quiet = 1'b0;

    // receiver holds off while commands keep coming
    wait_drained();
    hold_go = 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < 20; i++) send_cmd(FUNC_ADD, pick_vertex(), pick_vertex());

    // random graph phases over several vertex counts; shrunk graph keeps edges
    for (int p = 0; p < 8; p++) begin
      if (p % 3 == 0) write_vcount(7'($urandom_range(2, 20)));
      quiet = ($urandom_range(0, 3) == 0);
      graph_phase($urandom_range(0, 30), $urandom_range(4, 16));
      if (p % 5 == 4) begin
        write_vcount(7'($urandom_range(1, 64)));
        send_cmd(FUNC_RUN, 6'd0, 6'd0);
        send_cmd(3'($urandom_range(2, 5)), pick_comp(), pick_comp());
      end
    end
    quiet = 1'b0;

    wait (pending_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("** strongly_connected_components: PASSED **");
    end else begin
      $display("** strongly_connected_components: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #(12 * 3000000);
    $display("** strongly_connected_components: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
